>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BCBA_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");
`define BCBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error("assertion failed: %m");
`else
`define BCBA_ASSERT(name, prop)
`define BCBA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> rtl/bcba_pkg.sv
// ----------------------------------------------------------------------------
// bcba_pkg
// Types, sizes and codes of the bitmap contiguous block allocator.
// ----------------------------------------------------------------------------
package bcba_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORDS      = MAX_BLOCKS / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int CNT_W      = 13;
  localparam int BLK_W      = 12;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 13;

  localparam logic [CNT_W-1:0] MAX_BLOCKS_C     = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] TOTAL_RESET      = CNT_W'(4096);
  localparam logic [CNT_W-1:0] RESERVED_RESET   = '0;

  localparam logic [1:0] ACT_FORMAT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_TOTAL_BLOCKS    = 1'b0;
  localparam logic [CFG_AW-1:0] REG_RESERVED_BLOCKS = 1'b1;

  localparam logic STAT_OK       = 1'b0;
  localparam logic STAT_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [CNT_W-1:0] run_length;
    logic [BLK_W-1:0] block_number;
  } in_req_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] start_block;
  } out_rsp_t;

  typedef struct packed {
    logic               clear;
    logic               eval;
    logic [WORD_AW-1:0] word_idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] first_block;
    logic [BLK_W-1:0] end_block;
  } scan_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FMT,
    ST_SCAN,
    ST_LOCATE,
    ST_MARK,
    ST_REL_RD,
    ST_REL_WR,
    ST_RESP
  } state_t;

endpackage

>>> rtl/bcba_ram.sv
// ----------------------------------------------------------------------------
// bcba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bcba_fit_scan.sv
// ----------------------------------------------------------------------------
// bcba_fit_scan
// First-fit run search over one bitmap word per cycle, with the free run
// carried between words, and location of the first fitting run.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcba_fit_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bcba_pkg::scan_ctrl_t           ctrl,
  input  logic [bcba_pkg::WORD_BITS-1:0] word_used,
  input  logic [bcba_pkg::CNT_W-1:0]     run_len,
  input  logic [bcba_pkg::CNT_W-1:0]     span,
  output bcba_pkg::scan_stat_t           stat
);

  logic [bcba_pkg::CNT_W-1:0]     carry_r;
  logic [bcba_pkg::CNT_W-1:0]     carry_nxt;
  logic [bcba_pkg::CNT_W-1:0]     gap;
  logic                           found_r;
  logic [bcba_pkg::WORD_BITS-1:0] hit;
  logic [bcba_pkg::WORD_BITS-1:0] pos_ok;
  logic [bcba_pkg::WORD_BITS-1:0] hit_vec_r;
  logic [bcba_pkg::WORD_AW-1:0]   hit_word_r;
  logic [bcba_pkg::WORD_BITS-1:0] hv [bcba_pkg::BIT_AW+1];
  logic [bcba_pkg::BIT_AW-1:0]    hp [bcba_pkg::BIT_AW+1][bcba_pkg::WORD_BITS];
  logic [bcba_pkg::WORD_AW:0]     span_word;
  logic [bcba_pkg::BIT_AW-1:0]    span_bit;
  logic [bcba_pkg::BIT_AW-1:0]    first_pos;
  logic [bcba_pkg::BLK_W-1:0]     end_blk;
  logic [bcba_pkg::CNT_W-1:0]     first_blk;

  // highest used bit at or below each position, then run test per position
  always_comb begin
    int src;
    span_word = span[bcba_pkg::CNT_W-1:bcba_pkg::BIT_AW];
    span_bit  = span[bcba_pkg::BIT_AW-1:0];
    gap       = run_len - carry_r - bcba_pkg::CNT_W'(1);
    for (int i = 0; i < bcba_pkg::WORD_BITS; i++) begin
      hv[0][i] = word_used[i];
      hp[0][i] = bcba_pkg::BIT_AW'(i);
    end
    for (int d = 0; d < bcba_pkg::BIT_AW; d++) begin
      for (int i = 0; i < bcba_pkg::WORD_BITS; i++) begin
        src = (i >= (1 << d)) ? i - (1 << d) : i;
        if (!hv[d][i] && (i >= (1 << d))) begin
          hv[d+1][i] = hv[d][src];
          hp[d+1][i] = hp[d][src];
        end else begin
          hv[d+1][i] = hv[d][i];
          hp[d+1][i] = hp[d][i];
        end
      end
    end
    for (int i = 0; i < bcba_pkg::WORD_BITS; i++) begin
      pos_ok[i] = ({1'b0, ctrl.word_idx} < span_word) ||
                  (({1'b0, ctrl.word_idx} == span_word) &&
                   (bcba_pkg::BIT_AW'(i) < span_bit));
      if (hv[bcba_pkg::BIT_AW][i]) begin
        hit[i] = pos_ok[i] &&
                 ({{(bcba_pkg::CNT_W-bcba_pkg::BIT_AW){1'b0}},
                   bcba_pkg::BIT_AW'(i) - hp[bcba_pkg::BIT_AW][i]} >= run_len);
      end else begin
        hit[i] = pos_ok[i] && (bcba_pkg::CNT_W'(i) >= gap);
      end
    end
    if (hv[bcba_pkg::BIT_AW][bcba_pkg::WORD_BITS-1]) begin
      carry_nxt = {{(bcba_pkg::CNT_W-bcba_pkg::BIT_AW){1'b0}},
                   bcba_pkg::BIT_AW'(bcba_pkg::WORD_BITS-1) -
                   hp[bcba_pkg::BIT_AW][bcba_pkg::WORD_BITS-1]};
    end else begin
      carry_nxt = carry_r + bcba_pkg::CNT_W'(bcba_pkg::WORD_BITS);
    end
  end

  always_comb begin
    first_pos = '0;
    for (int i = bcba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (hit_vec_r[i]) begin
        first_pos = bcba_pkg::BIT_AW'(i);
      end
    end
    end_blk   = {hit_word_r, first_pos};
    first_blk = bcba_pkg::CNT_W'(end_blk) + bcba_pkg::CNT_W'(1) - run_len;
  end

  assign stat.found       = found_r;
  assign stat.first_block = first_blk[bcba_pkg::BLK_W-1:0];
  assign stat.end_block   = end_blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      found_r <= 1'b0;
    end else if (ctrl.clear) begin
      carry_r <= '0;
      found_r <= 1'b0;
    end else if (ctrl.eval && !found_r) begin
      carry_r <= carry_nxt;
      if (|hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.eval && !found_r && !ctrl.clear && (|hit)) begin
      hit_vec_r  <= hit;
      hit_word_r <= ctrl.word_idx;
    end
  end

  `BCBA_ASSERT(a_found_from_eval, $rose(found_r) |-> $past(ctrl.eval))
  `BCBA_ASSERT_NEXT(a_hit_word_held, found_r && !ctrl.clear, $stable(hit_word_r))

endmodule

>>> rtl/bitmap_contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// Used/free bitmap of disk blocks in a 64 x 64 RAM: format, first-fit
// contiguous allocate and single-block release.
//
//   channel  ports                          direction
//   request  in_valid/in_ready/in_req       in
//   result   out_valid/out_ready/out_rsp    out
//   config   cfg_we/cfg_addr/cfg_wdata      in
//
// One request at a time; every request gives one result.
// Format: one RAM word written per cycle.
// Allocate: scans the bitmap and then marks the run, reading one bitmap word
//   per cycle through the single read port.
// Release: read, modify, write of one word. Other codes go straight to the result.
// After reset every word reads as free until first written (per-word valid
//   bits, no clearing pass). A stalled result holds the block in ST_RESP.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_contiguous_block_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bcba_pkg::in_req_t           in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bcba_pkg::out_rsp_t          out_rsp,
  input  logic                        cfg_we,
  input  logic [bcba_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [bcba_pkg::CFG_DW-1:0] cfg_wdata
);

  bcba_pkg::state_t               state_r, state_nxt;
  logic [bcba_pkg::CNT_W-1:0]     total_r, reserved_r;
  logic [bcba_pkg::CNT_W-1:0]     span, lim, span_m1;
  logic [bcba_pkg::CNT_W-1:0]     len_r, len_nxt;
  logic [bcba_pkg::BLK_W-1:0]     blk_r, blk_nxt;
  logic [bcba_pkg::WORD_AW:0]     addr_r, addr_nxt;
  logic [bcba_pkg::WORD_AW-1:0]   end_word_r, end_word_nxt;
  logic [bcba_pkg::BLK_W-1:0]     start_r, start_nxt;
  logic [bcba_pkg::BLK_W-1:0]     run_last_r, run_last_nxt;
  logic                           rd_vld_r;
  logic [bcba_pkg::WORD_AW-1:0]   rd_word_r;
  logic                           rd_wv_r;
  logic                           last_eval_r, last_eval_nxt;
  logic [bcba_pkg::WORDS-1:0]     word_vld_r;
  bcba_pkg::out_rsp_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  bcba_pkg::out_rsp_t             out_rsp_r, out_rsp_nxt;

  logic                           ram_we, ram_re;
  logic [bcba_pkg::WORD_AW-1:0]   ram_waddr, ram_raddr;
  logic [bcba_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata, rd_data;
  logic [bcba_pkg::WORD_BITS-1:0] fmt_word, mark_mask;
  logic [bcba_pkg::BIT_AW-1:0]    mark_lo, mark_hi;
  logic                           accept;

  bcba_pkg::scan_ctrl_t           scan_ctrl;
  bcba_pkg::scan_stat_t           scan_stat;

  bcba_ram #(
    .WIDTH (bcba_pkg::WORD_BITS),
    .DEPTH (bcba_pkg::WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bcba_fit_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (scan_ctrl),
    .word_used (rd_data),
    .run_len   (len_r),
    .span      (span),
    .stat      (scan_stat)
  );

  assign span    = (total_r > bcba_pkg::MAX_BLOCKS_C) ? bcba_pkg::MAX_BLOCKS_C : total_r;
  assign lim     = (reserved_r > bcba_pkg::MAX_BLOCKS_C) ? bcba_pkg::MAX_BLOCKS_C : reserved_r;
  assign span_m1 = span - bcba_pkg::CNT_W'(1);
  assign rd_data = rd_wv_r ? ram_rdata : '0;
  assign accept  = in_valid && in_ready;

  assign in_ready  = (state_r == bcba_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // format pattern and run mask for the word at hand
  always_comb begin
    if ({1'b0, addr_r[bcba_pkg::WORD_AW-1:0]} < lim[bcba_pkg::CNT_W-1:bcba_pkg::BIT_AW]) begin
      fmt_word = '1;
    end else if ({1'b0, addr_r[bcba_pkg::WORD_AW-1:0]} ==
                 lim[bcba_pkg::CNT_W-1:bcba_pkg::BIT_AW]) begin
      fmt_word = ~({bcba_pkg::WORD_BITS{1'b1}} << lim[bcba_pkg::BIT_AW-1:0]);
    end else begin
      fmt_word = '0;
    end
    mark_lo = (rd_word_r == start_r[bcba_pkg::BLK_W-1:bcba_pkg::BIT_AW]) ?
              start_r[bcba_pkg::BIT_AW-1:0] : '0;
    mark_hi = (rd_word_r == end_word_r) ? run_last_r[bcba_pkg::BIT_AW-1:0] : '1;
    mark_mask = ({bcba_pkg::WORD_BITS{1'b1}} << mark_lo) &
                ({bcba_pkg::WORD_BITS{1'b1}} >> (~mark_hi));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcba_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_req.action)
            bcba_pkg::ACT_FORMAT: state_nxt = bcba_pkg::ST_FMT;
            bcba_pkg::ACT_ALLOC: begin
              if ((in_req.run_length == '0) || (span == '0)) begin
                state_nxt = bcba_pkg::ST_RESP;
              end else begin
                state_nxt = bcba_pkg::ST_SCAN;
              end
            end
            bcba_pkg::ACT_RELEASE: begin
              if (bcba_pkg::CNT_W'(in_req.block_number) < span) begin
                state_nxt = bcba_pkg::ST_REL_RD;
              end else begin
                state_nxt = bcba_pkg::ST_RESP;
              end
            end
            default: state_nxt = bcba_pkg::ST_RESP;
          endcase
        end
      end
      bcba_pkg::ST_FMT: begin
        if (addr_r == (bcba_pkg::WORD_AW+1)'(bcba_pkg::WORDS - 1)) begin
          state_nxt = bcba_pkg::ST_RESP;
        end
      end
      bcba_pkg::ST_SCAN: begin
        if (scan_stat.found) begin
          state_nxt = bcba_pkg::ST_LOCATE;
        end else if (last_eval_r) begin
          state_nxt = bcba_pkg::ST_RESP;
        end
      end
      bcba_pkg::ST_LOCATE: state_nxt = bcba_pkg::ST_MARK;
      bcba_pkg::ST_MARK: begin
        if (rd_vld_r && (rd_word_r == end_word_r)) begin
          state_nxt = bcba_pkg::ST_RESP;
        end
      end
      bcba_pkg::ST_REL_RD: state_nxt = bcba_pkg::ST_REL_WR;
      bcba_pkg::ST_REL_WR: state_nxt = bcba_pkg::ST_RESP;
      bcba_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = bcba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    len_nxt         = len_r;
    blk_nxt         = blk_r;
    addr_nxt        = addr_r;
    end_word_nxt    = end_word_r;
    start_nxt       = start_r;
    run_last_nxt    = run_last_r;
    res_nxt         = res_r;
    last_eval_nxt   = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_rsp_nxt     = out_rsp_r;
    ram_we          = 1'b0;
    ram_waddr       = rd_word_r;
    ram_wdata       = rd_data;
    ram_re          = 1'b0;
    ram_raddr       = addr_r[bcba_pkg::WORD_AW-1:0];
    scan_ctrl.clear = accept;
    scan_ctrl.eval  = 1'b0;
    scan_ctrl.word_idx = rd_word_r;
    unique case (state_r)
      bcba_pkg::ST_IDLE: begin
        if (accept) begin
          len_nxt      = in_req.run_length;
          blk_nxt      = in_req.block_number;
          addr_nxt     = '0;
          end_word_nxt = span_m1[bcba_pkg::BLK_W-1:bcba_pkg::BIT_AW];
          res_nxt.status      = (in_req.action == bcba_pkg::ACT_ALLOC) ?
                                bcba_pkg::STAT_NO_SPACE : bcba_pkg::STAT_OK;
          res_nxt.start_block = '0;
        end
      end
      bcba_pkg::ST_FMT: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r[bcba_pkg::WORD_AW-1:0];
        ram_wdata = fmt_word;
        addr_nxt  = addr_r + (bcba_pkg::WORD_AW+1)'(1);
      end
      bcba_pkg::ST_SCAN: begin
        ram_re         = (addr_r <= {1'b0, end_word_r}) && !scan_stat.found;
        addr_nxt       = addr_r + (bcba_pkg::WORD_AW+1)'(ram_re);
        scan_ctrl.eval = rd_vld_r && !scan_stat.found;
        last_eval_nxt  = scan_ctrl.eval && (rd_word_r == end_word_r);
      end
      bcba_pkg::ST_LOCATE: begin
        start_nxt    = scan_stat.first_block;
        run_last_nxt = scan_stat.end_block;
        addr_nxt     = {1'b0, scan_stat.first_block[bcba_pkg::BLK_W-1:bcba_pkg::BIT_AW]};
        end_word_nxt = scan_stat.end_block[bcba_pkg::BLK_W-1:bcba_pkg::BIT_AW];
        res_nxt.status      = bcba_pkg::STAT_OK;
        res_nxt.start_block = scan_stat.first_block;
      end
      bcba_pkg::ST_MARK: begin
        ram_re    = (addr_r <= {1'b0, end_word_r});
        addr_nxt  = addr_r + (bcba_pkg::WORD_AW+1)'(ram_re);
        ram_we    = rd_vld_r;
        ram_wdata = rd_data | mark_mask;
      end
      bcba_pkg::ST_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = blk_r[bcba_pkg::BLK_W-1:bcba_pkg::BIT_AW];
      end
      bcba_pkg::ST_REL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd_data &
                    ~({{(bcba_pkg::WORD_BITS-1){1'b0}}, 1'b1} << blk_r[bcba_pkg::BIT_AW-1:0]);
      end
      bcba_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcba_pkg::ST_IDLE;
      total_r     <= bcba_pkg::TOTAL_RESET;
      reserved_r  <= bcba_pkg::RESERVED_RESET;
      rd_vld_r    <= 1'b0;
      last_eval_r <= 1'b0;
      word_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= ram_re;
      last_eval_r <= last_eval_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        word_vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          bcba_pkg::REG_TOTAL_BLOCKS:    total_r    <= cfg_wdata;
          bcba_pkg::REG_RESERVED_BLOCKS: reserved_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    blk_r      <= blk_nxt;
    addr_r     <= addr_nxt;
    end_word_r <= end_word_nxt;
    start_r    <= start_nxt;
    run_last_r <= run_last_nxt;
    res_r      <= res_nxt;
    out_rsp_r  <= out_rsp_nxt;
    rd_word_r  <= ram_raddr;
    rd_wv_r    <= word_vld_r[ram_raddr];
  end

  `BCBA_ASSERT(a_no_rw_same_word, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `BCBA_ASSERT(a_mark_only_free, ((state_r == bcba_pkg::ST_MARK) && ram_we) |-> ((rd_data & mark_mask) == '0))
  `BCBA_ASSERT(a_run_in_span, (state_r == bcba_pkg::ST_LOCATE) |-> (bcba_pkg::CNT_W'(scan_stat.end_block) < span))

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - bitmap contiguous block allocator
// Sends format, allocate, release and unused-code requests through the
// request channel and checks every result against a bitmap kept in the
// testbench or against a table row. A short table of hand-picked requests
// comes first, then random traffic under a series of volume and reserved-area
// settings, with bursty input, a stalling result side, two long hold-offs.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 10;

  typedef enum logic [1:0] {ROW_WR, ROW_TYPED, ROW_PRED} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PULSE} rx_mode_t;

  typedef struct {
    row_kind_t                   kind;
    logic [bcba_pkg::CFG_AW-1:0] reg_idx;
    logic [bcba_pkg::CFG_DW-1:0] reg_val;
    bcba_pkg::in_req_t           req;
    bcba_pkg::out_rsp_t          rsp;
  } dir_row_t;

  typedef struct {
    logic [bcba_pkg::CNT_W-1:0] total;
    logic [bcba_pkg::CNT_W-1:0] reserved;
    int                         items;
    bit                         steady;
    bit                         hold;
  } phase_t;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  bcba_pkg::in_req_t           in_req    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  bcba_pkg::out_rsp_t          out_rsp;
  logic                        cfg_we    = 1'b0;
  logic [bcba_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [bcba_pkg::CFG_DW-1:0] cfg_wdata = '0;

  bit                         used_blk [bcba_pkg::MAX_BLOCKS];
  logic [bcba_pkg::CNT_W-1:0] vol_total    = bcba_pkg::TOTAL_RESET;
  logic [bcba_pkg::CNT_W-1:0] vol_reserved = bcba_pkg::RESERVED_RESET;
  bcba_pkg::out_rsp_t         awaited_rsp_q [$];

  bit       offering   = 1'b0;
  bit       steady     = 1'b0;
  int       burst_left = 0;
  bit       hold_arm   = 1'b0;
  int       hold_left  = 0;
  int       mode_left  = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  int mismatches   = 0;
  int n_checked    = 0;
  int n_req        = 0;
  int n_fmt        = 0;
  int n_placed     = 0;
  int n_refused    = 0;
  int n_free       = 0;
  int n_settings   = 0;
  int n_in_blocked = 0;

  bitmap_contiguous_block_allocator dut (.*);

  always #6 clk = ~clk;

  // ---- bitmap predictor ----

  function automatic bcba_pkg::out_rsp_t apply_to_bitmap(bcba_pkg::in_req_t r);
    bcba_pkg::out_rsp_t rsp;
    int                 span;
    int                 lim;
    int                 run;
    int                 hit;
    rsp.status      = bcba_pkg::STAT_OK;
    rsp.start_block = '0;
    span = (vol_total > bcba_pkg::MAX_BLOCKS) ? bcba_pkg::MAX_BLOCKS : int'(vol_total);
    case (r.action)
      bcba_pkg::ACT_FORMAT: begin
        lim = (vol_reserved > bcba_pkg::MAX_BLOCKS) ? bcba_pkg::MAX_BLOCKS :
              int'(vol_reserved);
        for (int i = 0; i < bcba_pkg::MAX_BLOCKS; i++) used_blk[i] = (i < lim);
      end
      bcba_pkg::ACT_ALLOC: begin
        rsp.status = bcba_pkg::STAT_NO_SPACE;
        run = 0;
        hit = -1;
        if (r.run_length != 0) begin
          for (int i = 0; i < span && hit < 0; i++) begin
            run = used_blk[i] ? 0 : run + 1;
            if (run == r.run_length) hit = i + 1 - int'(r.run_length);
          end
        end
        if (hit >= 0) begin
          for (int i = 0; i < int'(r.run_length); i++) used_blk[hit + i] = 1'b1;
          rsp.status      = bcba_pkg::STAT_OK;
          rsp.start_block = bcba_pkg::BLK_W'(hit);
        end
      end
      bcba_pkg::ACT_RELEASE: begin
        if (r.block_number < span) used_blk[r.block_number] = 1'b0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // ---- stimulus helpers ----

  function automatic dir_row_t req_row(row_kind_t kind, logic [1:0] act, int len, int blk,
                                       logic st = bcba_pkg::STAT_OK, int start = 0);
    dir_row_t row;
    row.kind                = kind;
    row.reg_idx             = '0;
    row.reg_val             = '0;
    row.req.action          = act;
    row.req.run_length      = bcba_pkg::CNT_W'(len);
    row.req.block_number    = bcba_pkg::BLK_W'(blk);
    row.rsp.status          = st;
    row.rsp.start_block     = bcba_pkg::BLK_W'(start);
    return row;
  endfunction

  function automatic dir_row_t wr_row(logic [bcba_pkg::CFG_AW-1:0] idx, int val);
    dir_row_t row;
    row         = req_row(ROW_WR, bcba_pkg::ACT_FORMAT, 0, 0);
    row.reg_idx = idx;
    row.reg_val = bcba_pkg::CFG_DW'(val);
    return row;
  endfunction

  function automatic bcba_pkg::in_req_t random_req();
    bcba_pkg::in_req_t r;
    int                span;
    int                pick;
    span           = (vol_total > bcba_pkg::MAX_BLOCKS) ? bcba_pkg::MAX_BLOCKS :
                     int'(vol_total);
    r.run_length   = bcba_pkg::CNT_W'($urandom);
    r.block_number = bcba_pkg::BLK_W'($urandom);
    pick           = $urandom_range(0, 99);
    if (pick < 3) begin
      r.action = bcba_pkg::ACT_FORMAT;
    end else if (pick < 55) begin
      r.action = bcba_pkg::ACT_ALLOC;
      pick     = $urandom_range(0, 99);
      if (pick < 4)       r.run_length = '0;
      else if (pick < 70) r.run_length = bcba_pkg::CNT_W'($urandom_range(1, 8));
      else if (pick < 88) r.run_length = bcba_pkg::CNT_W'($urandom_range(9, 64));
      else if (pick < 97)
        r.run_length = bcba_pkg::CNT_W'($urandom_range(1, (span > 1) ? span : 1));
    end else if (pick < 97) begin
      r.action = bcba_pkg::ACT_RELEASE;
      if (span > 0 && $urandom_range(0, 3) != 0)
        r.block_number = bcba_pkg::BLK_W'($urandom_range(0, span - 1));
    end else begin
      r.action = ACT_UNUSED;
    end
    return r;
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_request(input bcba_pkg::in_req_t r, input bit typed,
                              input bcba_pkg::out_rsp_t typed_rsp);
    int                 gap;
    bcba_pkg::out_rsp_t rsp;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = steady ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    rsp = apply_to_bitmap(r);
    awaited_rsp_q.push_back(typed ? typed_rsp : rsp);
    n_req++;
    case (r.action)
      bcba_pkg::ACT_FORMAT:  n_fmt++;
      bcba_pkg::ACT_ALLOC:   if (rsp.status == bcba_pkg::STAT_OK) n_placed++; else n_refused++;
      bcba_pkg::ACT_RELEASE: n_free++;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    drop_valid();
    while (awaited_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcba_pkg::CFG_AW-1:0] idx,
                           input logic [bcba_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == bcba_pkg::REG_TOTAL_BLOCKS) vol_total = val;
    else vol_reserved = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  // ---- result side ----

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= mode_left[3];
      endcase
    end
  end

  always @(posedge clk) begin : check_rsp
    bcba_pkg::out_rsp_t want;
    if (rst_n && in_valid && !in_ready) n_in_blocked++;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_rsp_q.size() == 0) begin
        flag($sformatf("result status=%0d start=%0d with no request pending",
                       out_rsp.status, out_rsp.start_block));
      end else begin
        want = awaited_rsp_q.pop_front();
        if (out_rsp.status !== want.status)
          flag($sformatf("result %0d status: expected %0d, got %0d",
                         n_checked, want.status, out_rsp.status));
        if (out_rsp.start_block !== want.start_block)
          flag($sformatf("result %0d start_block: expected %0d, got %0d",
                         n_checked, want.start_block, out_rsp.start_block));
        n_checked++;
      end
    end
  end

  initial begin
    #15_000_000;
    $display("timeout with %0d results still pending", awaited_rsp_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---- main sequence ----

  initial begin : stimulus
    dir_row_t          tab [$];
    phase_t            plan [$];
    bcba_pkg::in_req_t r;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 0, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 4096, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 4096, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0, bcba_pkg::STAT_OK, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 8191, 4095,
                          bcba_pkg::STAT_NO_SPACE));
    tab.push_back(req_row(ROW_TYPED, ACT_UNUSED, 8191, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 8191, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_FORMAT, 8191, 4095));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 3, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 5, 0, bcba_pkg::STAT_OK, 3));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 1));
    tab.push_back(req_row(ROW_PRED, bcba_pkg::ACT_ALLOC, 2, 0));
    tab.push_back(wr_row(bcba_pkg::REG_TOTAL_BLOCKS, 9));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 9));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 10, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(req_row(ROW_PRED, bcba_pkg::ACT_ALLOC, 1, 0));
    tab.push_back(wr_row(bcba_pkg::REG_RESERVED_BLOCKS, 8191));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_FORMAT, 0, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(wr_row(bcba_pkg::REG_TOTAL_BLOCKS, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0, bcba_pkg::STAT_NO_SPACE));
    tab.push_back(wr_row(bcba_pkg::REG_TOTAL_BLOCKS, 8191));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_RELEASE, 0, 0));
    tab.push_back(req_row(ROW_TYPED, bcba_pkg::ACT_ALLOC, 1, 0));
    tab.push_back(req_row(ROW_PRED, bcba_pkg::ACT_ALLOC, 4096, 0));
    tab.push_back(wr_row(bcba_pkg::REG_RESERVED_BLOCKS, 0));

    foreach (tab[i]) begin
      if (tab[i].kind == ROW_WR) begin
        wait_drained();
        write_reg(tab[i].reg_idx, tab[i].reg_val);
        n_settings++;
      end else begin
        send_request(tab[i].req, tab[i].kind == ROW_TYPED, tab[i].rsp);
      end
    end

    plan.push_back('{13'd4096, 13'd0,    150, 1'b0, 1'b0});
    plan.push_back('{13'd64,   13'd3,    130, 1'b0, 1'b0});
    plan.push_back('{13'd1,    13'd0,    60,  1'b0, 1'b0});
    plan.push_back('{13'd200,  13'd17,   150, 1'b1, 1'b1});
    plan.push_back('{13'd8191, 13'd8191, 80,  1'b0, 1'b0});
    plan.push_back('{13'd130,  13'd129,  80,  1'b0, 1'b0});
    plan.push_back('{13'd4096, 13'd4000, 150, 1'b0, 1'b0});
    plan.push_back('{13'd0,    13'd0,    50,  1'b0, 1'b0});
    plan.push_back('{13'd1000, 13'd300,  150, 1'b1, 1'b1});
    plan.push_back('{13'd77,   13'd90,   100, 1'b0, 1'b0});
    plan.push_back('{13'd300,  13'd0,    200, 1'b1, 1'b0});

    foreach (plan[p]) begin
      wait_drained();
      write_reg(bcba_pkg::REG_TOTAL_BLOCKS, plan[p].total);
      write_reg(bcba_pkg::REG_RESERVED_BLOCKS, plan[p].reserved);
      n_settings++;
      steady     = plan[p].steady;
      burst_left = 0;
      r          = random_req();
      r.action   = bcba_pkg::ACT_FORMAT;
      send_request(r, 1'b0, '0);
      for (int k = 1; k < plan[p].items; k++) begin
        if (plan[p].hold && k == 10) hold_arm = 1'b1;
        if (k == plan[p].items / 2) wait_drained();
        send_request(random_req(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d requests over %0d volume settings: %0d runs placed, %0d refused,",
             n_req, n_settings, n_placed, n_refused);
    $display("  %0d frees, %0d formats; input held back %0d cycles; %0d results checked",
             n_free, n_fmt, n_in_blocked, n_checked);
    if (mismatches == 0 && awaited_rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
